@@ rtl/edtp_pkg.sv @@
// edtp_pkg: shared types, constants and helpers for the earliest deadline task picker
// no dependencies; imported by edtp_cell and earliest_deadline_task_picker
package edtp_pkg;

    localparam int NUM_TASKS_DEF = 4;
    localparam int IDX_W         = 4;
    localparam int VAL_W         = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [VAL_W-1:0] HORIZON_RST  = 16'd20;
    localparam logic [VAL_W-1:0] CEILING_RST  = 16'd10000;
    localparam logic [VAL_W-1:0] VAL_MAX      = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd1;

    // item kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // running best candidate handed from cell to cell
    typedef struct packed {
        logic [VAL_W-1:0] best;
        logic [IDX_W-1:0] idx;
        logic             found;
        logic [VAL_W-1:0] burst;
        logic [VAL_W-1:0] marker;
        logic [VAL_W-1:0] count;
    } scan_t;

    // write and run commands broadcast to all cells
    typedef struct packed {
        logic             load;
        logic             run;
        logic [IDX_W-1:0] sel;
        logic [VAL_W-1:0] burst;
        logic [VAL_W-1:0] deadline;
        logic [VAL_W-1:0] period;
    } cell_cmd_t;

    // saturating 16-bit add
    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
    endfunction

endpackage

@@ rtl/edtp_cell.sv @@
// edtp_cell: one task entry plus one compare stage of the scan chain
// depends on edtp_pkg
module edtp_cell import edtp_pkg::*; #(
    parameter int INDEX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  scan_t     chain_in,
    output scan_t     chain_out
);

    logic [VAL_W-1:0] burst_reg;
    logic [VAL_W-1:0] period_reg;
    logic [VAL_W-1:0] deadline_reg;
    logic [VAL_W-1:0] marker_reg;
    logic [VAL_W-1:0] count_reg;
    scan_t            chain_reg;
    scan_t            chain_next;
    logic             hit;

    assign hit = (cmd.sel == IDX_W'(INDEX));

    // task entry: load writes it, a run advances it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg    <= '0;
            period_reg   <= '0;
            deadline_reg <= VAL_MAX;
            marker_reg   <= '0;
            count_reg    <= '0;
        end else if (cmd.load && hit) begin
            burst_reg    <= cmd.burst;
            period_reg   <= cmd.period;
            deadline_reg <= cmd.deadline;
            marker_reg   <= cmd.period;
            count_reg    <= '0;
        end else if (cmd.run && hit) begin
            deadline_reg <= sat_add(deadline_reg, period_reg);
            marker_reg   <= sat_add(marker_reg, period_reg);
            count_reg    <= sat_add(count_reg, VAL_W'(1));
        end
    end

    // strict compare keeps the lower index on ties
    always_comb begin
        chain_next = chain_in;
        if (deadline_reg < chain_in.best) begin
            chain_next.best   = deadline_reg;
            chain_next.idx    = IDX_W'(INDEX);
            chain_next.found  = 1'b1;
            chain_next.burst  = burst_reg;
            chain_next.marker = marker_reg;
            chain_next.count  = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        chain_reg <= chain_next;
    end

    assign chain_out = chain_reg;

endmodule

@@ rtl/earliest_deadline_task_picker.sv @@
// earliest_deadline_task_picker: top level, sequencer and chain of task cells
// depends on edtp_pkg and edtp_cell
// a load goes straight to the finish step, a step scans the chain first;
// no new item is taken until the previous result is registered
// the scan walks one cell of the chain per cycle
// synchronous reset (aresetn low): tables, clock, state, config and out valid reset
module earliest_deadline_task_picker import edtp_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,  // task_index[3:0], task_burst[19:4],
                                           // task_first_deadline[35:20], task_period[51:36]
    input  logic [0:0]           s_tuser,  // func[0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,  // chosen_task[3:0], found[4], ran[5],
                                           // clock_now[21:6], run_count[37:22], finished[38]
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    localparam int CNT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]   horizon_reg, ceiling_reg;
    logic [VAL_W-1:0]   clock_reg, clock_next;
    logic               func_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VAL_W-1:0]   burst_reg, deadline_reg, period_reg;
    logic               out_valid_reg;
    logic [39:0]        out_data_reg, out_data_next;

    logic               in_fire, out_free, done_fire, scan_last;
    logic               idx_ok, run_ok;
    logic [VAL_W-1:0]   count_out;
    scan_t              chain [NUM_TASKS+1];
    scan_t              result;
    cell_cmd_t          cmd;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign scan_last = (cnt_reg == CNT_W'(NUM_TASKS - 1));
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            horizon_reg <= HORIZON_RST;
            ceiling_reg <= CEILING_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_HORIZON: horizon_reg <= cfg_data;
                REG_CEILING: ceiling_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg     <= s_tuser[0];
            idx_reg      <= s_tdata[3:0];
            burst_reg    <= s_tdata[19:4];
            deadline_reg <= s_tdata[35:20];
            period_reg   <= s_tdata[51:36];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_tuser[0] == FUNC_STEP) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        done_fire = 1'b0;
        cnt_next  = '0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SCAN: cnt_next = cnt_reg + CNT_W'(1);
            ST_DONE: done_fire = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // chain head starts from the ceiling with nothing found
    assign chain[0] = '{best: ceiling_reg, idx: '0, found: 1'b0,
                        burst: '0, marker: '0, count: '0};

    for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
        edtp_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .chain_in (chain[i]),
            .chain_out(chain[i+1])
        );
    end

    assign result = chain[NUM_TASKS];

    // run decision and clock update
    assign idx_ok = ({1'b0, idx_reg} < (IDX_W+1)'(NUM_TASKS));
    assign run_ok = result.found && (clock_reg < horizon_reg) &&
                    (result.marker >= clock_reg);

    always_comb begin
        cmd.load     = done_fire && (func_reg == FUNC_LOAD) && idx_ok;
        cmd.run      = done_fire && (func_reg == FUNC_STEP) && run_ok;
        cmd.sel      = (func_reg == FUNC_LOAD) ? idx_reg : result.idx;
        cmd.burst    = burst_reg;
        cmd.deadline = deadline_reg;
        cmd.period   = period_reg;
    end

    always_comb begin
        clock_next = clock_reg;
        if (cmd.load) begin
            clock_next = '0;
        end else if (cmd.run) begin
            clock_next = sat_add(clock_reg, result.burst);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= '0;
        end else if (done_fire) begin
            clock_reg <= clock_next;
        end
    end

    // result word
    always_comb begin
        count_out = '0;
        if (result.found) begin
            count_out = run_ok ? sat_add(result.count, VAL_W'(1)) : result.count;
        end
        out_data_next = '0;
        out_data_next[21:6] = clock_next;
        out_data_next[38]   = (clock_next >= horizon_reg);
        if (func_reg == FUNC_STEP) begin
            out_data_next[3:0]   = result.found ? result.idx : '0;
            out_data_next[4]     = result.found;
            out_data_next[5]     = run_ok;
            out_data_next[37:22] = count_out;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_fire) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("item transfer did not start work");

    a_run_needs_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.run |-> (result.found && (clock_reg < horizon_reg)))
        else $error("task run without a valid pick");

    a_done_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        done_fire |=> m_tvalid)
        else $error("finished item produced no result");

    a_scan_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(NUM_TASKS - 1)))
        else $error("scan counter past the last cell");

    a_no_cmd_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load || cmd.run) |-> (state_reg == ST_DONE) && !(cmd.load && cmd.run))
        else $error("cell command outside the finish step");
`endif

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for earliest_deadline_task_picker
// depends on edtp_pkg and the picker rtl; holds its own scheduling model and checks every result
`timescale 1ns / 1ps

module tb;
    import edtp_pkg::*;

    localparam int  NT          = NUM_TASKS_DEF;
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  PHASE_ITEMS = 110;
    localparam int  HOLD_AFTER  = 200;
    localparam int  HOLD_CYCLES = 400;
    localparam int  LAST_STEPS  = 40;
    localparam logic TYPED      = 1'b1;
    localparam logic PREDICTED  = 1'b0;

    typedef struct packed {
        logic             func;
        logic [3:0]       idx;
        logic [VAL_W-1:0] burst;
        logic [VAL_W-1:0] deadline;
        logic [VAL_W-1:0] period;
    } task_item_t;

    typedef struct packed {
        logic [3:0]       chosen;
        logic             found;
        logic             ran;
        logic [VAL_W-1:0] clock_now;
        logic [VAL_W-1:0] run_count;
        logic             finished;
    } pick_result_t;

    // per-item tag: a typed-in expectation or one from the model
    typedef struct packed {
        logic         typed;
        pick_result_t want;
    } item_tag_t;

    typedef struct packed {
        task_item_t   item;
        logic         typed;
        pick_result_t want;
    } directed_row_t;

    localparam pick_result_t NO_PICK = '0;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [55:0]          s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;

    // scheduler model state
    logic [VAL_W-1:0] burst_tab    [NT] = '{default: '0};
    logic [VAL_W-1:0] period_tab   [NT] = '{default: '0};
    logic [VAL_W-1:0] deadline_tab [NT] = '{default: VAL_MAX};
    logic [VAL_W-1:0] marker_tab   [NT] = '{default: '0};
    logic [VAL_W-1:0] count_tab    [NT] = '{default: '0};
    logic [VAL_W-1:0] clk_model   = '0;
    logic [VAL_W-1:0] horizon_cfg = HORIZON_RST;
    logic [VAL_W-1:0] ceiling_cfg = CEILING_RST;

    item_tag_t    tag_q[$];
    pick_result_t expected_picks[$];

    logic idle_on = 1'b0;
    int   cycles = 0;
    int   mismatch_count = 0;
    int   results_seen = 0;
    int   loads_sent = 0;
    int   steps_sent = 0;
    int   runs_seen = 0;
    int   finished_seen = 0;
    int   cfg_writes = 0;

    // directed items: extremes, ties, out-of-range load, marker below clock,
    // horizon reached, deadline at the ceiling, saturation
    localparam int NUM_DIRECTED = 22;
    localparam int SAT_START    = 14;
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      TYPED, NO_PICK},
        '{'{FUNC_LOAD, 4'd15, 16'hFFFF,   16'd0,      16'hFFFF},   TYPED, NO_PICK},
        '{'{FUNC_LOAD, 4'd0,  16'd5,      16'd100,    16'd50},     TYPED, NO_PICK},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      TYPED,
          '{4'd0, 1'b1, 1'b1, 16'd5, 16'd1, 1'b0}},
        '{'{FUNC_LOAD, 4'd1,  16'd3,      16'd150,    16'd0},      TYPED, NO_PICK},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      PREDICTED, NO_PICK},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      PREDICTED, NO_PICK},
        '{'{FUNC_LOAD, 4'd2,  16'd0,      16'd9999,   16'd1},      TYPED, NO_PICK},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      PREDICTED, NO_PICK},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      PREDICTED, NO_PICK},
        '{'{FUNC_LOAD, 4'd3,  16'd20,     16'd0,      16'd7},      TYPED, NO_PICK},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      TYPED,
          '{4'd3, 1'b1, 1'b1, 16'd20, 16'd1, 1'b1}},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      PREDICTED, NO_PICK},
        '{'{FUNC_LOAD, 4'd3,  16'd0,      16'd10000,  16'd0},      TYPED, NO_PICK},
        // horizon and ceiling at their top value from here on
        '{'{FUNC_LOAD, 4'd1,  16'd0,      16'hFFFF,   16'd0},      TYPED, NO_PICK},
        '{'{FUNC_LOAD, 4'd2,  16'd0,      16'hFFFF,   16'd0},      TYPED, NO_PICK},
        '{'{FUNC_LOAD, 4'd3,  16'd0,      16'hFFFF,   16'd0},      TYPED, NO_PICK},
        '{'{FUNC_LOAD, 4'd0,  16'hFFFF,   16'hFFFE,   16'hFFFF},   TYPED, NO_PICK},
        '{'{FUNC_STEP, 4'd15, 16'hFFFF,   16'hFFFF,   16'hFFFF},   TYPED,
          '{4'd0, 1'b1, 1'b1, 16'hFFFF, 16'd1, 1'b1}},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      TYPED,
          '{4'd0, 1'b0, 1'b0, 16'hFFFF, 16'd0, 1'b1}},
        '{'{FUNC_LOAD, 4'd1,  16'd1,      16'd0,      16'd0},      TYPED, NO_PICK},
        '{'{FUNC_STEP, 4'd0,  16'd0,      16'd0,      16'd0},      PREDICTED, NO_PICK}
    };

    earliest_deadline_task_picker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [VAL_W-1:0] sat16(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
        int unsigned s;
        s = a + b;
        return (s > 32'hFFFF) ? VAL_MAX : s[VAL_W-1:0];
    endfunction

    // one item through the scheduler model, updating its state
    function automatic pick_result_t schedule_item(input task_item_t it);
        pick_result_t     r;
        logic [VAL_W-1:0] best;
        int               i;
        r = '0;
        if (it.func == FUNC_LOAD) begin
            if (it.idx < NT) begin
                burst_tab[it.idx]    = it.burst;
                deadline_tab[it.idx] = it.deadline;
                period_tab[it.idx]   = it.period;
                marker_tab[it.idx]   = it.period;
                count_tab[it.idx]    = '0;
                clk_model            = '0;
            end
        end else begin
            best = ceiling_cfg;
            for (i = 0; i < NT; i++) begin
                if (deadline_tab[i] < best) begin
                    best     = deadline_tab[i];
                    r.chosen = i[3:0];
                    r.found  = 1'b1;
                end
            end
            if (r.found) begin
                if (clk_model < horizon_cfg && marker_tab[r.chosen] >= clk_model) begin
                    clk_model               = sat16(clk_model, burst_tab[r.chosen]);
                    deadline_tab[r.chosen]  = sat16(deadline_tab[r.chosen], period_tab[r.chosen]);
                    marker_tab[r.chosen]    = sat16(marker_tab[r.chosen], period_tab[r.chosen]);
                    count_tab[r.chosen]     = sat16(count_tab[r.chosen], 16'd1);
                    r.ran                   = 1'b1;
                end
                r.run_count = count_tab[r.chosen];
            end
        end
        r.clock_now = clk_model;
        r.finished  = (clk_model >= horizon_cfg);
        return r;
    endfunction

    // mostly within max, now and then any 16-bit value
    function automatic logic [VAL_W-1:0] pick16(input int unsigned max);
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, max));
    endfunction

    function automatic task_item_t make_item(input logic func, input int unsigned burst_max,
                                             input int unsigned dl_max);
        task_item_t it;
        it.func     = func;
        it.idx      = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, NT - 1));
        it.burst    = pick16(burst_max);
        it.deadline = pick16(dl_max);
        it.period   = pick16(burst_max + 8);
        return it;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: result %0d %s expected %0d actual %0d",
                     $time, results_seen, name, want, got);
            mismatch_count++;
        end
    endtask

    // offer one item and hold it until its transfer
    task automatic send_item(input task_item_t it, input logic typed, input pick_result_t want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        tag_q.push_back('{typed, want});
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.period, it.deadline, it.burst, it.idx};
        s_tuser  <= it.func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // register write, only once every result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        s_tvalid <= 1'b0;
        while (tag_q.size() != 0 || expected_picks.size() != 0) @(posedge aclk);
        repeat (NT + 4) @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // result check, then register and item transfers into the model
    always @(posedge aclk) begin : monitor
        pick_result_t got;
        pick_result_t want;
        item_tag_t    tag;
        task_item_t   it;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[3:0], m_tdata[4], m_tdata[5], m_tdata[21:6],
                       m_tdata[37:22], m_tdata[38]};
                results_seen++;
                runs_seen     += got.ran;
                finished_seen += got.finished;
                if (expected_picks.size() == 0) begin
                    $display("%0t: result %0d with none expected, actual %h",
                             $time, results_seen, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_picks.pop_front();
                    compare_field("chosen_task", want.chosen, got.chosen);
                    compare_field("found", want.found, got.found);
                    compare_field("ran", want.ran, got.ran);
                    compare_field("clock_now", want.clock_now, got.clock_now);
                    compare_field("run_count", want.run_count, got.run_count);
                    compare_field("finished", want.finished, got.finished);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HORIZON: horizon_cfg = cfg_data;
                    REG_CEILING: ceiling_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                it.func     = s_tuser[0];
                it.idx      = s_tdata[3:0];
                it.burst    = s_tdata[19:4];
                it.deadline = s_tdata[35:20];
                it.period   = s_tdata[51:36];
                if (it.func == FUNC_LOAD)
                    loads_sent++;
                else
                    steps_sent++;
                want = schedule_item(it);
                tag  = tag_q.pop_front();
                expected_picks.push_back(tag.typed ? tag.want : want);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_picks.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off to back the block up
    initial begin : sink
        int hold_cycles;
        bit held;
        held     = 1'b0;
        m_tready = 1'b1;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++)
                    @(posedge aclk);
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        task_item_t       it;
        logic [VAL_W-1:0] hz;
        logic [VAL_W-1:0] ceil_v;
        int unsigned      burst_max;
        int unsigned      dl_max;
        int               phase_items;
        int               n;
        int               k;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        idle_on = 1'b1;
        for (k = 0; k < NUM_DIRECTED; k++) begin
            if (k == SAT_START) begin
                write_reg(REG_HORIZON, VAL_MAX);
                write_reg(REG_CEILING, VAL_MAX);
            end
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
        end

        // random phases, one register setting each
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin hz = 16'd20;    ceil_v = 16'd200;   end
                1: begin hz = VAL_MAX;   ceil_v = VAL_MAX;   end
                2: begin hz = 16'd1;     ceil_v = 16'd1;     end
                3: begin
                    hz     = 16'($urandom_range(1, 65535));
                    ceil_v = 16'($urandom_range(1, 65535));
                end
                4: begin hz = 16'd500;   ceil_v = 16'd40000; end
                default: begin hz = 16'd100; ceil_v = 16'd300; end
            endcase
            write_reg(REG_HORIZON, hz);
            write_reg(REG_CEILING, ceil_v);
            idle_on   = ($urandom_range(0, 3) != 0);
            burst_max = hz / 4 + 1;
            dl_max    = ceil_v + ceil_v / 16;
            if (dl_max > 65535)
                dl_max = 65535;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: kinds in any order
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++) begin
                        it = make_item(1'($urandom), burst_max, dl_max);
                        send_item(it, PREDICTED, NO_PICK);
                    end
                    phase_items += n;
                end else begin
                    // a task set, then a run of scheduling steps
                    n = $urandom_range(1, NT);
                    for (k = 0; k < n; k++) begin
                        it = make_item(FUNC_LOAD, burst_max, dl_max);
                        send_item(it, PREDICTED, NO_PICK);
                    end
                    phase_items += n;
                    n = $urandom_range(1, 10);
                    for (k = 0; k < n; k++) begin
                        it = make_item(FUNC_STEP, burst_max, dl_max);
                        send_item(it, PREDICTED, NO_PICK);
                    end
                    phase_items += n;
                end
            end
        end

        // last stretch, no idling: one zero-burst task runs on every step, back to back
        idle_on = 1'b0;
        write_reg(REG_HORIZON, 16'd1);
        write_reg(REG_CEILING, 16'd1);
        for (k = 0; k < NT; k++) begin
            it = '{FUNC_LOAD, 4'(k), 16'd0, (k == 0) ? 16'd0 : VAL_MAX, 16'd0};
            send_item(it, PREDICTED, NO_PICK);
        end
        it = '{FUNC_STEP, 4'd0, 16'd0, 16'd0, 16'd0};
        for (k = 0; k < LAST_STEPS; k++)
            send_item(it, PREDICTED, NO_PICK);
        s_tvalid <= 1'b0;

        // drain
        while (tag_q.size() != 0 || expected_picks.size() != 0) @(posedge aclk);
        repeat (4 * NT + 8) @(posedge aclk);
        $display("covered %0d loads and %0d steps over %0d register writes, %0d results checked",
                 loads_sent, steps_sent, cfg_writes, results_seen);
        $display("%0d steps ran a task, %0d results at the horizon, %0d mismatches",
                 runs_seen, finished_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/edtp_pkg.sv
rtl/edtp_cell.sv
rtl/earliest_deadline_task_picker.sv
tb/sv/tb.sv
